// ===== hdl/tsmq_pkg.sv =====
// Shared types, codes and tree-sizing functions for the time-sorted message queue.
// No dependencies; imported by tsmq_cell, tsmq_or_tree and the top level.
package tsmq_pkg;

  localparam int POS_W    = 6;
  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int FAN_IN   = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_PEEK   = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-item control broadcast to every cell.
  typedef struct packed {
    logic             ins_en;   // insert accepted and room left
    logic             rem_en;   // pop or remove of a held entry
    logic             rd_en;    // pop, remove or peek of a held entry
    logic [POS_W-1:0] sel_pos;  // addressed position (zero for pop)
  } cell_ctrl_t;

  // Nodes on tree level lvl (level -1 is the leaf row).
  function automatic int tree_nodes(int depth, int lvl);
    int n;
    n = depth;
    for (int k = 0; k <= lvl; k++) begin
      n = (n + FAN_IN - 1) / FAN_IN;
    end
    return n;
  endfunction

  // Registered levels needed to fold depth leaves into one node.
  function automatic int tree_levels(int depth);
    int n;
    int l;
    n = (depth + FAN_IN - 1) / FAN_IN;
    l = 1;
    while (n > 1) begin
      n = (n + FAN_IN - 1) / FAN_IN;
      l++;
    end
    return l;
  endfunction

  // Start of level lvl in the flattened node array.
  function automatic int tree_offset(int depth, int lvl);
    int s;
    s = 0;
    for (int k = 0; k < lvl; k++) begin
      s += tree_nodes(depth, k);
    end
    return s;
  endfunction

endpackage

// ===== hdl/tsmq_cell.sv =====
// One slot of the sorted chain: holds a time and handle, shifts with its neighbors.
// Depends on tsmq_pkg.
module tsmq_cell #(
  parameter int IDX         = 0,
  parameter int CNT_W       = 7,
  parameter int TIME_BITS   = 32,
  parameter int HANDLE_BITS = 16
) (
  input  logic                            clk_i,
  input  tsmq_pkg::cell_ctrl_t            ctrl_i,
  input  logic [CNT_W-1:0]                occ_i,
  input  logic [TIME_BITS-1:0]            new_time_i,
  input  logic [HANDLE_BITS-1:0]          new_handle_i,
  input  logic                            left_after_i,
  input  logic [TIME_BITS-1:0]            left_time_i,
  input  logic [HANDLE_BITS-1:0]          left_handle_i,
  input  logic [TIME_BITS-1:0]            right_time_i,
  input  logic [HANDLE_BITS-1:0]          right_handle_i,
  output logic                            after_o,
  output logic [TIME_BITS-1:0]            time_o,
  output logic [HANDLE_BITS-1:0]          handle_o,
  output logic [HANDLE_BITS+TIME_BITS-1:0] leaf_o
);
  import tsmq_pkg::*;

  logic [TIME_BITS-1:0]   time_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic                   valid_c;
  logic                   at_or_past_c;
  logic                   hit_c;

  assign valid_c      = 32'(IDX) < 32'(occ_i);
  assign at_or_past_c = 32'(IDX) >= 32'(ctrl_i.sel_pos);
  assign hit_c        = ctrl_i.rd_en && (32'(IDX) == 32'(ctrl_i.sel_pos));

  // Empty slot or later time: new entry lands here or further left.
  assign after_o = !valid_c || (time_q > new_time_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_en && after_o) begin
      if (left_after_i) begin
        time_q   <= left_time_i;
        handle_q <= left_handle_i;
      end else begin
        time_q   <= new_time_i;
        handle_q <= new_handle_i;
      end
    end else if (ctrl_i.rem_en && at_or_past_c) begin
      time_q   <= right_time_i;
      handle_q <= right_handle_i;
    end
  end

  assign time_o   = time_q;
  assign handle_o = handle_q;
  assign leaf_o   = hit_c ? {handle_q, time_q} : '0;

endmodule

// ===== hdl/tsmq_or_tree.sv =====
// Registered OR tree, fan-in 8, folding the one-hot cell read-out into one word.
// Depends on tsmq_pkg.
module tsmq_or_tree #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] leaf_i [DEPTH],
  output logic [WIDTH-1:0] root_o
);
  import tsmq_pkg::*;

  localparam int LEVELS = tree_levels(DEPTH);
  localparam int TOTAL  = tree_offset(DEPTH, LEVELS);

  logic [WIDTH-1:0] node_q [TOTAL];

  for (genvar lv = 0; lv < LEVELS; lv++) begin : g_lvl
    localparam int NN  = tree_nodes(DEPTH, lv);
    localparam int NP  = tree_nodes(DEPTH, lv - 1);
    localparam int OFS = tree_offset(DEPTH, lv);
    localparam int OFP = tree_offset(DEPTH, lv - 1);
    for (genvar j = 0; j < NN; j++) begin : g_node
      logic [WIDTH-1:0] kid_c [FAN_IN];
      logic [WIDTH-1:0] sum_c;
      for (genvar k = 0; k < FAN_IN; k++) begin : g_kid
        if (j * FAN_IN + k < NP) begin : g_real
          if (lv == 0) begin : g_leaf
            assign kid_c[k] = leaf_i[j*FAN_IN+k];
          end else begin : g_inner
            assign kid_c[k] = node_q[OFP+j*FAN_IN+k];
          end
        end else begin : g_pad
          assign kid_c[k] = '0;
        end
      end
      always_comb begin
        sum_c = '0;
        for (int k = 0; k < FAN_IN; k++) begin
          sum_c = sum_c | kid_c[k];
        end
      end
      always_ff @(posedge clk_i) begin
        node_q[OFS+j] <= sum_c;
      end
    end
  end

  assign root_o = node_q[TOTAL-1];

endmodule

// ===== hdl/time_sorted_message_queue_unit.sv =====
// Top level of the time-sorted message queue: cell chain, read-out tree, result pipe.
// Depends on tsmq_pkg, tsmq_cell and tsmq_or_tree.
//
//  channel  | handshake     | payload
//  ---------+---------------+--------------------------------------------------
//  command  | start / busy  | opcode_i, message_handle_i, deliver_time_i, position_i
//  result   | done_o strobe | status_o, out_handle_o, out_time_o, entry_count_o
//
// Cycles: one item per clock. Entries live in a chain of DEPTH cells; every cell
//   compares its time with the incoming one and shifts left or right in the same
//   edge, so the queue state is final at the accept edge and the next item sees it.
// Read-out: the read-out goes through an OR tree of fan-in 8 with a register per
//   level, and a result pipe with a register per level keeps done_o, status_o and
//   entry_count_o aligned with the tree output.
// Reset: clears occupancy and the valid bits of the result pipe; cell contents
//   stay undefined and are never read before being written.
// Stalls: busy stays low; results are strobed once and cannot be held off.
module time_sorted_message_queue_unit #(
  parameter int DEPTH       = 64,
  parameter int TIME_BITS   = 32,
  parameter int HANDLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [tsmq_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [HANDLE_BITS-1:0]              message_handle_i,
  input  logic [TIME_BITS-1:0]                deliver_time_i,
  input  logic [tsmq_pkg::POS_W-1:0]          position_i,
  output logic                                done_o,
  output logic [tsmq_pkg::STATUS_W-1:0]       status_o,
  output logic [HANDLE_BITS-1:0]              out_handle_o,
  output logic [TIME_BITS-1:0]                out_time_o,
  output logic [tsmq_pkg::COUNT_W-1:0]        entry_count_o
);
  import tsmq_pkg::*;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = HANDLE_BITS + TIME_BITS;
  localparam int LEVELS = tree_levels(DEPTH);

  // ---- occupancy and command decode ----
  logic [CNT_W-1:0] occ_q, occ_d;
  logic             accept_c;
  opcode_e          op_c;
  logic [POS_W-1:0] sel_pos_c;
  logic             full_c;
  logic             in_range_c;
  cell_ctrl_t       ctrl_c;
  status_e          status_c;

  assign busy     = 1'b0;
  assign accept_c = start && !busy;
  assign op_c     = opcode_e'(opcode_i);

  // Pop addresses the head.
  assign sel_pos_c  = (op_c == OP_POP) ? '0 : position_i;
  assign full_c     = 32'(occ_q) >= 32'(DEPTH);
  assign in_range_c = 32'(sel_pos_c) < 32'(occ_q);

  always_comb begin
    ctrl_c         = '0;
    ctrl_c.sel_pos = sel_pos_c;
    status_c       = ST_OK;
    occ_d          = occ_q;
    if (accept_c) begin
      case (op_c)
        OP_INSERT: begin
          if (full_c) begin
            status_c = ST_FULL;
          end else begin
            ctrl_c.ins_en = 1'b1;
            occ_d         = occ_q + CNT_W'(1);
          end
        end
        OP_POP, OP_REMOVE: begin
          if (in_range_c) begin
            ctrl_c.rem_en = 1'b1;
            ctrl_c.rd_en  = 1'b1;
            occ_d         = occ_q - CNT_W'(1);
          end else begin
            status_c = ST_RANGE;
          end
        end
        OP_PEEK: begin
          if (in_range_c) begin
            ctrl_c.rd_en = 1'b1;
          end else begin
            status_c = ST_RANGE;
          end
        end
        default: status_c = ST_RANGE;
      endcase
    end
  end

  // ---- cell chain ----
  logic [TIME_BITS-1:0]   cell_time   [DEPTH];
  logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
  logic                   cell_after  [DEPTH];
  logic [WORD_W-1:0]      cell_leaf   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   l_after;
    logic [TIME_BITS-1:0]   l_time;
    logic [HANDLE_BITS-1:0] l_handle;
    logic [TIME_BITS-1:0]   r_time;
    logic [HANDLE_BITS-1:0] r_handle;

    if (i == 0) begin : g_head
      assign l_after  = 1'b0;
      assign l_time   = '0;
      assign l_handle = '0;
    end else begin : g_body
      assign l_after  = cell_after[i-1];
      assign l_time   = cell_time[i-1];
      assign l_handle = cell_handle[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_time   = '0;
      assign r_handle = '0;
    end else begin : g_mid
      assign r_time   = cell_time[i+1];
      assign r_handle = cell_handle[i+1];
    end

    tsmq_cell #(
      .IDX         (i),
      .CNT_W       (CNT_W),
      .TIME_BITS   (TIME_BITS),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl_c),
      .occ_i          (occ_q),
      .new_time_i     (deliver_time_i),
      .new_handle_i   (message_handle_i),
      .left_after_i   (l_after),
      .left_time_i    (l_time),
      .left_handle_i  (l_handle),
      .right_time_i   (r_time),
      .right_handle_i (r_handle),
      .after_o        (cell_after[i]),
      .time_o         (cell_time[i]),
      .handle_o       (cell_handle[i]),
      .leaf_o         (cell_leaf[i])
    );
  end

  // ---- read-out tree ----
  logic [WORD_W-1:0] root_c;

  tsmq_or_tree #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (cell_leaf),
    .root_o (root_c)
  );

  // ---- result pipe, aligned with the tree ----
  logic          pipe_vld_q [LEVELS];
  status_e       pipe_st_q  [LEVELS];
  logic [CNT_W-1:0] pipe_cnt_q [LEVELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      for (int s = 0; s < LEVELS; s++) begin
        pipe_vld_q[s] <= 1'b0;
      end
    end else begin
      occ_q         <= occ_d;
      pipe_vld_q[0] <= accept_c;
      for (int s = 1; s < LEVELS; s++) begin
        pipe_vld_q[s] <= pipe_vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_st_q[0]  <= status_c;
    pipe_cnt_q[0] <= occ_d;
    for (int s = 1; s < LEVELS; s++) begin
      pipe_st_q[s]  <= pipe_st_q[s-1];
      pipe_cnt_q[s] <= pipe_cnt_q[s-1];
    end
  end

  assign done_o        = pipe_vld_q[LEVELS-1];
  assign status_o      = pipe_st_q[LEVELS-1];
  assign out_time_o    = root_c[TIME_BITS-1:0];
  assign out_handle_o  = root_c[WORD_W-1:TIME_BITS];
  assign entry_count_o = COUNT_W'(pipe_cnt_q[LEVELS-1]);

  // ---- checks ----
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= 32'(DEPTH))
    else $error("occupancy above depth");

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_c |-> ##LEVELS done_o)
    else $error("result strobe missing after accept");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pipe_st_q[LEVELS-1] == ST_FULL) |-> 32'(pipe_cnt_q[LEVELS-1]) == 32'(DEPTH))
    else $error("full status with room left");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_c && op_c == OP_INSERT && !full_c) |=> occ_q == $past(occ_q) + CNT_W'(1))
    else $error("insert did not grow the queue");

  a_peek_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_c && op_c == OP_PEEK) |=> occ_q == $past(occ_q))
    else $error("peek changed occupancy");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for time_sorted_message_queue_unit: directed and random items,
// each reply compared with a shadow copy of the sorted queue. Needs tsmq_pkg and the RTL.
module testbench;
  import tsmq_pkg::*;

  localparam int DEPTH        = 64;
  localparam int TIME_BITS    = 32;
  localparam int HANDLE_BITS  = 16;
  localparam int DRAIN_CYCLES = 8;     // idle cycles after the last reply, to catch stray strobes
  localparam int WAIT_LIMIT   = 1000;  // cycles allowed for outstanding replies

  // One reply as the unit should return it.
  typedef struct {
    status_e                status;
    logic [HANDLE_BITS-1:0] handle;
    logic [TIME_BITS-1:0]   dtime;
    logic [COUNT_W-1:0]     count;
  } reply_t;

  // Random traffic shapes: fill pushes toward full, drain toward empty.
  typedef enum int {
    TM_FILL,
    TM_DRAIN,
    TM_MIXED
  } traffic_mode_e;

  // Shadow of the sorted queue plus the replies still owed by the unit.
  class queue_shadow;
    logic [TIME_BITS-1:0]   times[DEPTH];
    logic [HANDLE_BITS-1:0] handles[DEPTH];
    int                     occ;
    int                     errors;
    int                     replies_seen;
    reply_t                 expected_replies[$];

    task flag_mismatch(string msg);
      errors++;
      $display("%0t MISMATCH: %s", $realtime, msg);
    endtask

    // Pull slot p out and close the gap.
    function void take_entry(int p, output logic [HANDLE_BITS-1:0] h,
                             output logic [TIME_BITS-1:0] t);
      int i;
      h = handles[p];
      t = times[p];
      for (i = p; i + 1 < occ; i++) begin
        handles[i] = handles[i + 1];
        times[i]   = times[i + 1];
      end
      occ--;
    endfunction

    // Called for every accepted item: update the shadow and queue the reply.
    function void note_item(opcode_e op, logic [HANDLE_BITS-1:0] h,
                            logic [TIME_BITS-1:0] t, logic [POS_W-1:0] pos);
      reply_t r;
      int     slot;
      int     i;
      r.status = ST_OK;
      r.handle = '0;
      r.dtime  = '0;
      case (op)
        OP_INSERT: begin
          if (occ >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // equal times: new entry lands after the existing ones
            slot = 0;
            while (slot < occ && times[slot] <= t) slot++;
            for (i = occ; i > slot; i--) begin
              handles[i] = handles[i - 1];
              times[i]   = times[i - 1];
            end
            handles[slot] = h;
            times[slot]   = t;
            occ++;
          end
        end
        OP_POP: begin
          if (occ == 0) r.status = ST_RANGE;
          else take_entry(0, r.handle, r.dtime);
        end
        default: begin
          if (int'(pos) >= occ) begin
            r.status = ST_RANGE;
          end else if (op == OP_REMOVE) begin
            take_entry(int'(pos), r.handle, r.dtime);
          end else begin
            r.handle = handles[pos];
            r.dtime  = times[pos];
          end
        end
      endcase
      r.count = COUNT_W'(occ);
      expected_replies.push_back(r);
    endfunction

    // Called for every strobed reply: compare with the oldest one owed.
    task check_reply(logic [STATUS_W-1:0] st, logic [HANDLE_BITS-1:0] h,
                     logic [TIME_BITS-1:0] t, logic [COUNT_W-1:0] n);
      reply_t r;
      replies_seen++;
      if (expected_replies.size() == 0) begin
        flag_mismatch($sformatf("reply %0d with nothing owed: status %0d handle %h",
                                replies_seen, st, h));
        return;
      end
      r = expected_replies.pop_front();
      if (st !== r.status)
        flag_mismatch($sformatf("reply %0d status %0d, want %0d", replies_seen, st, r.status));
      if (h !== r.handle)
        flag_mismatch($sformatf("reply %0d handle %h, want %h", replies_seen, h, r.handle));
      if (t !== r.dtime)
        flag_mismatch($sformatf("reply %0d time %h, want %h", replies_seen, t, r.dtime));
      if (n !== r.count)
        flag_mismatch($sformatf("reply %0d count %0d, want %0d", replies_seen, n, r.count));
    endtask
  endclass

  // Clock, reset and unit inputs all start at known values.
  logic                   clk_i            = 1'b0;
  logic                   rst_ni           = 1'b0;
  logic                   start            = 1'b0;
  logic [OPCODE_W-1:0]    opcode_i         = OP_PEEK;
  logic [HANDLE_BITS-1:0] message_handle_i = '0;
  logic [TIME_BITS-1:0]   deliver_time_i   = '0;
  logic [POS_W-1:0]       position_i       = '0;
  logic                   busy;
  logic                   done_o;
  logic [STATUS_W-1:0]    status_o;
  logic [HANDLE_BITS-1:0] out_handle_o;
  logic [TIME_BITS-1:0]   out_time_o;
  logic [COUNT_W-1:0]     entry_count_o;

  queue_shadow shadow = new;
  int          sender_idle_pct = 0;  // chance per cycle that the sender holds back

  always #5 clk_i = ~clk_i;

  time_sorted_message_queue_unit #(
    .DEPTH      (DEPTH),
    .TIME_BITS  (TIME_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .message_handle_i(message_handle_i),
    .deliver_time_i  (deliver_time_i),
    .position_i      (position_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .out_handle_o    (out_handle_o),
    .out_time_o      (out_time_o),
    .entry_count_o   (entry_count_o)
  );

  // Monitor: sampled at the rising edge, so both handshakes see pre-edge values.
  // Items are noted before replies are checked; the read-out pipe keeps any reply
  // on this edge older than an item accepted on it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy)
        shadow.note_item(opcode_e'(opcode_i), message_handle_i, deliver_time_i, position_i);
      if ($isunknown(done_o))
        shadow.flag_mismatch("done strobe unknown");
      else if (done_o)
        shadow.check_reply(status_o, out_handle_o, out_time_o, entry_count_o);
    end
  end

  // Present one item and hold it until the unit takes it. Idle cycles come first,
  // so start is only ever lowered or raised once per edge.
  task automatic issue_item(opcode_e op, logic [HANDLE_BITS-1:0] h,
                            logic [TIME_BITS-1:0] t, logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start            <= 1'b1;
    opcode_i         <= op;
    message_handle_i <= h;
    deliver_time_i   <= t;
    position_i       <= pos;
    do @(posedge clk_i); while (busy);
  endtask

  // Sort keys: extremes, a narrow band that forces ties, and full-range values.
  function automatic logic [TIME_BITS-1:0] rand_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return TIME_BITS'($urandom_range(0, 7));
      default: return TIME_BITS'($urandom);
    endcase
  endfunction

  // Mostly a held position, sometimes anything the field allows.
  function automatic logic [POS_W-1:0] rand_pos();
    if (shadow.occ > 0 && $urandom_range(0, 9) < 7)
      return POS_W'($urandom_range(0, shadow.occ - 1));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  task automatic random_items(traffic_mode_e mode, int n_items);
    opcode_e op;
    int      roll;
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      case (mode)
        TM_FILL: begin
          if (roll < 80) op = OP_INSERT;
          else op = OP_PEEK;
        end
        TM_DRAIN: begin
          if (roll < 40) op = OP_POP;
          else if (roll < 80) op = OP_REMOVE;
          else op = OP_PEEK;
        end
        default: op = opcode_e'($urandom_range(0, 3));
      endcase
      issue_item(op, HANDLE_BITS'($urandom), rand_time(), rand_pos());
    end
  endtask

  // Hard stop in case the unit hangs or never strobes a reply.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int waited;
    waited = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: everything on an empty queue is out of range.
    issue_item(OP_POP,    HANDLE_BITS'($urandom), rand_time(), 6'd0);
    issue_item(OP_REMOVE, HANDLE_BITS'($urandom), rand_time(), 6'd0);
    issue_item(OP_PEEK,   HANDLE_BITS'($urandom), rand_time(), 6'd63);
    // Extremes of handle and time; a zero time must land ahead of the head.
    issue_item(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
    issue_item(OP_INSERT, 16'h0000, 32'h0000_0000, 6'd0);
    // Ties in the middle and at the top keep arrival order.
    issue_item(OP_INSERT, 16'h5555, 32'd5, 6'h2A);
    issue_item(OP_INSERT, 16'hAAAA, 32'd5, 6'h15);
    issue_item(OP_INSERT, 16'h1234, 32'd5, 6'd0);
    issue_item(OP_INSERT, 16'h0001, 32'hFFFF_FFFF, 6'd0);
    issue_item(OP_INSERT, 16'h00FF, 32'hAAAA_5555, 6'd0);
    // Seven held: peek both ends, then one past the last (off-by-one edge).
    issue_item(OP_PEEK,   HANDLE_BITS'($urandom), rand_time(), 6'd0);
    issue_item(OP_PEEK,   HANDLE_BITS'($urandom), rand_time(), 6'd6);
    issue_item(OP_PEEK,   HANDLE_BITS'($urandom), rand_time(), 6'd7);
    issue_item(OP_REMOVE, HANDLE_BITS'($urandom), rand_time(), 6'd7);
    issue_item(OP_PEEK,   HANDLE_BITS'($urandom), rand_time(), 6'd2);
    // Remove at the head, in the middle and at the tail.
    issue_item(OP_REMOVE, HANDLE_BITS'($urandom), rand_time(), 6'd0);
    issue_item(OP_REMOVE, HANDLE_BITS'($urandom), rand_time(), 6'd2);
    issue_item(OP_REMOVE, HANDLE_BITS'($urandom), rand_time(), 6'd4);
    issue_item(OP_POP,    HANDLE_BITS'($urandom), rand_time(), 6'd0);
    issue_item(OP_PEEK,   HANDLE_BITS'($urandom), rand_time(), 6'd63);
    // Drain the rest and pop once more on empty.
    repeat (4) issue_item(OP_POP, HANDLE_BITS'($urandom), rand_time(), 6'd0);

    // Random, no idling: fill to the brim, then keep knocking on a full queue.
    sender_idle_pct = 0;
    while (shadow.occ < DEPTH) random_items(TM_FILL, 1);
    random_items(TM_FILL, 8);

    // Sparse sender: drain through pops and removes down to empty and past it.
    sender_idle_pct = 62;
    while (shadow.occ > 0) random_items(TM_DRAIN, 1);
    random_items(TM_DRAIN, 4);

    // Moderate gaps with any opcode mix.
    sender_idle_pct = 34;
    random_items(TM_MIXED, 100);

    // Back to back: short fill and drain bursts around mid occupancy.
    sender_idle_pct = 0;
    repeat (4) begin
      random_items(TM_FILL, 15);
      random_items(TM_DRAIN, 12);
    end

    // Stop sending, let outstanding replies arrive, then watch for strays.
    start <= 1'b0;
    while (shadow.expected_replies.size() != 0 && waited < WAIT_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (shadow.expected_replies.size() != 0)
      shadow.flag_mismatch($sformatf("%0d replies never arrived",
                                     shadow.expected_replies.size()));

    if (shadow.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
